// ----- src/sdpq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the sorted delay priority queue.
package sdpq_pkg;

	localparam int COUNT_W = 5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_PEEK   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  task_handle;
		logic [31:0] delay_key;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         head_task;
		logic [31:0]        head_key;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  task_handle;
		logic [31:0] delay_key;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       cap;
		logic       rd;
		logic       idx_dn;
		logic       idx_up;
		logic       place_after;
		logic       place_head;
		logic       move_up;
		logic       move_down;
		logic       cap_head;
		logic       cnt_dec;
		logic       emit;
		logic [1:0] emit_status;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic key_ge;
		logic rd_at_zero;
		logic idx_at_cnt;
	} sts_t;

endpackage

// ----- src/sdpq_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the sorted delay priority queue: entry store, pointers, count and result register.
module sdpq_datapath import sdpq_pkg::*; #(
	parameter int POOL_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  ctl_t ctl,
	output sts_t sts,
	output logic done,
	output rsp_t rsp
);

	localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CW = $clog2(POOL_SIZE + 1);

	entry_t          mem_q [POOL_SIZE];
	entry_t          rdata_q;
	logic [AW-1:0]   rd_addr_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   count_q;
	entry_t          new_q;
	entry_t          head_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_addr_q + AW'(1);
		wr_data = rdata_q;
		if (ctl.place_after) begin
			wr_en   = 1'b1;
			wr_data = new_q;
		end else if (ctl.place_head) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = new_q;
		end else if (ctl.move_up) begin
			wr_en = 1'b1;
		end else if (ctl.move_down) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_q - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rdata_q   <= mem_q[idx_q[AW-1:0]];
			rd_addr_q <= idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			new_q.task_handle <= req.task_handle;
			new_q.delay_key   <= req.delay_key;
			head_q            <= '0;
		end else if (ctl.cap_head) begin
			head_q <= rdata_q;
		end
	end

	// An insert walks down from the tail; a remove walks up from the head, and a peek reads the head alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			if (ctl.cap) begin
				idx_q <= (req.cmd == CMD_INSERT) ? count_q - CW'(1) : '0;
			end else if (ctl.idx_dn) begin
				idx_q <= idx_q - CW'(1);
			end else if (ctl.idx_up) begin
				idx_q <= idx_q + CW'(1);
			end
			if (ctl.place_after || ctl.place_head) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			rsp_q.status      <= ctl.emit_status;
			rsp_q.head_task   <= head_q.task_handle;
			rsp_q.head_key    <= head_q.delay_key;
			rsp_q.entry_count <= COUNT_W'(count_q);
		end
	end

	always_comb begin
		sts.cnt_zero   = (count_q == '0);
		sts.cnt_full   = (count_q == CW'(POOL_SIZE));
		sts.key_ge     = (rdata_q.delay_key >= new_q.delay_key);
		sts.rd_at_zero = (rd_addr_q == '0);
		sts.idx_at_cnt = (idx_q == count_q);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- src/sdpq_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the sorted delay priority queue.
module sdpq_ctrl import sdpq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	input  sts_t       sts,
	output logic       busy,
	output ctl_t       ctl
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_INS_RD   = 4'd1;
	localparam logic [3:0] S_INS_CMP  = 4'd2;
	localparam logic [3:0] S_INS_HEAD = 4'd3;
	localparam logic [3:0] S_REM_RD   = 4'd4;
	localparam logic [3:0] S_REM_CAP  = 4'd5;
	localparam logic [3:0] S_REM_MOVE = 4'd6;
	localparam logic [3:0] S_PEEK_RD  = 4'd7;
	localparam logic [3:0] S_PEEK_CAP = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] st_q;
	logic [1:0] st_d;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		ctl     = '0;
		ctl.emit_status = st_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.cap = 1'b1;
					st_d    = ST_OK;
					case (cmd)
						CMD_INSERT: begin
							if (sts.cnt_full) begin
								st_d    = ST_FULL;
								state_d = S_DONE;
							end else if (sts.cnt_zero) begin
								state_d = S_INS_HEAD;
							end else begin
								state_d = S_INS_RD;
							end
						end
						CMD_REMOVE: begin
							if (sts.cnt_zero) begin
								st_d    = ST_EMPTY;
								state_d = S_DONE;
							end else begin
								state_d = S_REM_RD;
							end
						end
						default: begin
							if (sts.cnt_zero) begin
								st_d    = ST_EMPTY;
								state_d = S_DONE;
							end else begin
								state_d = S_PEEK_RD;
							end
						end
					endcase
				end
			end
			S_INS_RD: begin
				ctl.rd     = 1'b1;
				ctl.idx_dn = 1'b1;
				state_d    = S_INS_CMP;
			end
			S_INS_CMP: begin
				// Stop at the first entry whose key is not below the new key.
				if (sts.key_ge) begin
					ctl.place_after = 1'b1;
					state_d         = S_DONE;
				end else begin
					ctl.move_up = 1'b1;
					if (sts.rd_at_zero) begin
						state_d = S_INS_HEAD;
					end else begin
						ctl.rd     = 1'b1;
						ctl.idx_dn = 1'b1;
					end
				end
			end
			S_INS_HEAD: begin
				ctl.place_head = 1'b1;
				state_d        = S_DONE;
			end
			S_REM_RD: begin
				ctl.rd     = 1'b1;
				ctl.idx_up = 1'b1;
				state_d    = S_REM_CAP;
			end
			S_REM_CAP: begin
				ctl.cap_head = 1'b1;
				if (sts.idx_at_cnt) begin
					ctl.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					ctl.rd     = 1'b1;
					ctl.idx_up = 1'b1;
					state_d    = S_REM_MOVE;
				end
			end
			S_REM_MOVE: begin
				ctl.move_down = 1'b1;
				if (sts.idx_at_cnt) begin
					ctl.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					ctl.rd     = 1'b1;
					ctl.idx_up = 1'b1;
				end
			end
			S_PEEK_RD: begin
				ctl.rd  = 1'b1;
				state_d = S_PEEK_CAP;
			end
			S_PEEK_CAP: begin
				ctl.cap_head = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				ctl.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- src/sorted_delay_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Top level of the sorted delay priority queue.
// A request is taken when start is high and busy is low; busy then stays high until the
// result is ready, and the result appears on rsp with done high for exactly one cycle, with
// nothing able to hold it off. Entries live in a store with one read and one write port,
// walked one entry per cycle, so the time from request to result is set by that walk: an
// insert walks down from the tail past each entry below the new key, a remove moves each
// entry after the first one place toward the head, a peek or an insert into an empty queue
// touches only the head, and a full insert or an empty remove or peek goes straight to the result.
// A new request is taken in the same cycle that the result is shown.
module sorted_delay_priority_queue_unit import sdpq_pkg::*; #(
	parameter int POOL_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	ctl_t ctl;
	sts_t sts;

	sdpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (req.cmd),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	sdpq_datapath #(
		.POOL_SIZE (POOL_SIZE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but busy did not rise");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.head_task == '0 && rsp.head_key == '0))
		else $error("failed request carries nonzero head fields");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> (rsp.entry_count == COUNT_W'(POOL_SIZE)))
		else $error("full status without a full count");
`endif

endmodule
